### src/bucketed_transposition_table_top_macros.svh
// Assertion macros shared by the transposition table RTL.
`ifndef BUCKETED_TRANSPOSITION_TABLE_TOP_MACROS_SVH
`define BUCKETED_TRANSPOSITION_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/btt_pkg.sv
// Package with the shared types and constants of the transposition table.
package btt_pkg;
    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_NEWGEN = 2'd2;
    localparam logic [1:0] ST_MATE = 2'd0;
    localparam logic [1:0] ST_NOMATE = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;
    localparam logic [7:0] UNKNOWN = 8'hFF;
    localparam int EW = 64 + 8 + 8 + 8 + 1 + 16;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_OUT
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  gen;
        logic [7:0]  mate;
        logic [7:0]  lim;
        logic        nomate;
        logic [15:0] move;
    } t_entry;

    typedef struct packed {
        logic clear_en;
        logic clear_start;
        logic latch_in;
        logic read_en;
        logic exec;
        logic gen_inc;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic op_newgen;
        logic gen_last;
    } t_stat;

    function automatic t_entry empty_entry();
        t_entry e;
        e.key = '0; e.gen = '0; e.mate = UNKNOWN; e.lim = UNKNOWN;
        e.nomate = 1'b0; e.move = '0;
        return e;
    endfunction
endpackage

### src/btt_ram.sv
// Generic single-port-write, registered-read RAM.
module btt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/btt_datapath.sv
// Datapath: bucket memories, lookup, victim choice, merge and result register.
`include "bucketed_transposition_table_top_macros.svh"
module btt_datapath #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btt_pkg::t_cmd      i_cmd,
    output btt_pkg::t_stat     o_stat,
    input  logic [1:0]         i_opcode,
    input  logic [63:0]        i_key,
    input  logic [7:0]         i_remaining,
    input  logic [1:0]         i_result_status,
    input  logic [7:0]         i_proof_plies,
    input  logic [15:0]        i_packed_move,
    output logic [26:0]        o_result
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [1:0]  r_op;
    logic [63:0] r_key;
    logic [7:0]  r_rem, r_plies;
    logic [1:0]  r_st;
    logic [15:0] r_move;
    logic [7:0]  r_gen;
    logic [BW-1:0] r_clr;
    logic [26:0] r_res;

    logic [BW-1:0] bidx;
    assign bidx = (BUCKETS > 1) ? BW'(i_key % 64'(BUCKETS)) : '0;
    logic [BW-1:0] r_bidx;

    btt_pkg::t_entry rd [WAYS];
    btt_pkg::t_entry wr_e;
    logic [WW-1:0] wsel;
    logic          do_write;

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        logic we;
        logic [btt_pkg::EW-1:0] q;
        assign we = i_cmd.clear_en || (do_write && wsel == WW'(w));
        btt_ram #(.WIDTH(btt_pkg::EW), .DEPTH(BUCKETS)) u_ram (
            .i_clk(i_clk), .i_we(we),
            .i_waddr(i_cmd.clear_en ? r_clr : r_bidx),
            .i_wdata(i_cmd.clear_en ? btt_pkg::EW'(btt_pkg::empty_entry()) : wr_e),
            .i_re(i_cmd.read_en), .i_raddr(r_bidx), .o_rdata(q));
        assign rd[w] = btt_pkg::t_entry'(q);
    end

    // Hit search and victim choice across ways.
    logic          hit_f;
    logic [WW-1:0] hit_w, vic_w;
    logic [10:0]   vval, bestv;
    always_comb begin
        hit_f = 1'b0; hit_w = '0; vic_w = '0; bestv = 11'h7FF; vval = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit_f && rd[w].gen == r_gen && rd[w].key == r_key) begin
                hit_f = 1'b1; hit_w = WW'(w);
            end
            if (rd[w].gen != r_gen) vval = 11'd0;
            else if (rd[w].mate != btt_pkg::UNKNOWN || rd[w].nomate) vval = 11'd1002;
            else if (rd[w].lim == btt_pkg::UNKNOWN) vval = 11'd1;
            else vval = 11'(rd[w].lim) + 11'd2;
            if (vval < bestv) begin
                bestv = vval; vic_w = WW'(w);
            end
        end
    end

    btt_pkg::t_entry cur;
    logic [26:0] pres;
    always_comb begin
        cur = hit_f ? rd[hit_w] : btt_pkg::empty_entry();
        if (!hit_f) begin
            cur.key = r_key; cur.gen = r_gen;
        end
        wr_e = cur;
        case (r_st)
            btt_pkg::ST_MATE: begin
                if (cur.mate == btt_pkg::UNKNOWN || r_plies < cur.mate) begin
                    wr_e.mate = r_plies; wr_e.move = r_move;
                end
            end
            btt_pkg::ST_NOMATE: begin
                wr_e.nomate = 1'b1; wr_e.move = r_move;
            end
            btt_pkg::ST_LIMIT: begin
                if (cur.lim == btt_pkg::UNKNOWN || r_rem > cur.lim) begin
                    wr_e.lim = r_rem;
                    if (cur.mate == btt_pkg::UNKNOWN && !cur.nomate) wr_e.move = r_move;
                end
            end
            default: wr_e = cur;
        endcase
        wsel = hit_f ? hit_w : vic_w;
        do_write = i_cmd.exec && r_op == btt_pkg::OP_STORE;
        pres = '0;
        if (hit_f) begin
            if (cur.nomate) pres = {8'd0, cur.move, btt_pkg::ST_NOMATE, 1'b1};
            else if (cur.mate != btt_pkg::UNKNOWN && cur.mate <= r_rem)
                pres = {cur.mate, cur.move, btt_pkg::ST_MATE, 1'b1};
            else if (cur.lim != btt_pkg::UNKNOWN && cur.lim >= r_rem)
                pres = {8'd0, cur.move, btt_pkg::ST_LIMIT, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= 8'd1;
            r_clr <= '0;
        end else begin
            if (i_cmd.clear_start) r_clr <= '0;
            else if (i_cmd.clear_en) r_clr <= r_clr + BW'(1);
            if (i_cmd.gen_inc) r_gen <= (r_gen == 8'hFF) ? 8'd1 : r_gen + 8'd1;
        end
        if (i_cmd.latch_in) begin
            r_op <= i_opcode; r_key <= i_key; r_rem <= i_remaining;
            r_st <= i_result_status; r_plies <= i_proof_plies;
            r_move <= i_packed_move; r_bidx <= bidx;
        end
        if (i_cmd.exec) r_res <= (r_op == btt_pkg::OP_PROBE) ? pres : '0;
    end

    assign o_stat.clear_done = (r_clr == BW'(BUCKETS - 1));
    assign o_stat.op_newgen = (r_op == btt_pkg::OP_NEWGEN);
    assign o_stat.gen_last = (r_gen == 8'hFF);
    assign o_result = r_res;

    `BTT_ASSERT_IMP(a_gen_nonzero, i_clk, i_rst_n, 1'b1, r_gen != 8'd0)
    `BTT_ASSERT_IMP(a_no_write_clear, i_clk, i_rst_n, i_cmd.clear_en, !do_write)
    `BTT_ASSERT_NEXT(a_gen_step, i_clk, i_rst_n, i_cmd.gen_inc && r_gen != 8'hFF,
        r_gen == $past(r_gen) + 8'd1)
endmodule

### src/btt_ctrl.sv
// Controller state machine sequencing clear, read, execute and output.
`include "bucketed_transposition_table_top_macros.svh"
module btt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output btt_pkg::t_cmd  o_cmd,
    input  btt_pkg::t_stat i_stat
);
    btt_pkg::t_state r_state, n_state;
    logic r_wrap, n_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btt_pkg::S_CLEAR;
            r_wrap <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wrap <= n_wrap;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wrap = r_wrap;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            btt_pkg::S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = r_wrap ? btt_pkg::S_OUT : btt_pkg::S_IDLE;
                    n_wrap = 1'b0;
                end
            end
            btt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.latch_in = 1'b1;
                if (i_in_valid) n_state = btt_pkg::S_READ;
            end
            btt_pkg::S_READ: begin
                o_cmd.read_en = 1'b1;
                n_state = btt_pkg::S_EXEC;
            end
            btt_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = btt_pkg::S_OUT;
                if (i_stat.op_newgen) begin
                    o_cmd.gen_inc = 1'b1;
                    if (i_stat.gen_last) begin
                        o_cmd.clear_start = 1'b1;
                        n_wrap = 1'b1;
                        n_state = btt_pkg::S_CLEAR;
                    end
                end
            end
            btt_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = btt_pkg::S_IDLE;
            end
            default: n_state = btt_pkg::S_IDLE;
        endcase
    end

    `BTT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == btt_pkg::S_IDLE)
    `BTT_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `BTT_ASSERT_NEXT(a_accept_read, i_clk, i_rst_n, o_in_ready && i_in_valid,
        r_state == btt_pkg::S_READ)
endmodule

### src/bucketed_transposition_table_top.sv
// Top level of the set-associative transposition table.
// After a word is accepted, its bucket is read, then merged with write-back
// into the result register, and the result is offered; no new word is taken
// until that result is taken. A tag wrap adds a sweep that clears all BUCKETS
// buckets; after synchronous reset the same sweep runs before the first word.
module bucketed_transposition_table_top #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode[1:0], key[65:2], remaining[73:66], result_status[75:74],
    // proof_plies[83:76], packed_move[99:84], zero fill to 104 bits.
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit[0], hit_status[2:1], hit_move[18:3], hit_plies[26:19], zero fill.
    output logic [31:0]  m_tdata
);
    btt_pkg::t_cmd  cmd;
    btt_pkg::t_stat stat;
    logic [26:0] res;

    // The controller sees the latched opcode and the generation wrap only
    // through the datapath's status signals.
    btt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_tvalid), .o_in_ready(s_tready),
        .o_out_valid(m_tvalid), .i_out_ready(m_tready),
        .o_cmd(cmd), .i_stat(stat));

    btt_datapath #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_opcode(s_tdata[1:0]), .i_key(s_tdata[65:2]),
        .i_remaining(s_tdata[73:66]), .i_result_status(s_tdata[75:74]),
        .i_proof_plies(s_tdata[83:76]), .i_packed_move(s_tdata[99:84]),
        .o_result(res));

    assign m_tdata = {5'd0, res};
endmodule
